[rtl/sitda_pkg.sv]
`timescale 1ns / 1ps

package sitda_pkg;

   localparam int VALUE_WIDTH_DEFAULT = 32;

   localparam logic [7:0] CHAR_ZERO  = 8'd48;
   localparam logic [7:0] CHAR_MINUS = 8'd45;

   // Decimal digits needed for a magnitude of up to 2^(w-1). The factor
   // 1233/4096 is slightly below log10(2), but it is applied to w, not w-1.
   function automatic int num_digits(input int w);
      return ((w * 1233) >> 12) + 1;
   endfunction

   typedef struct packed {
      logic load;
      logic conv_step;
      logic emit_sign;
      logic emit_digit;
      logic drop_digit;
   } cmd_type;

   typedef struct packed {
      logic conv_last;
      logic negative;
      logic top_zero;
      logic one_left;
      logic out_free;
   } status_type;

endpackage

[rtl/signed_int_to_decimal_ascii_unit.sv]
// Channel   Direction  Handshake                 Payload
// req       in         req_valid / req_stall     req_value (signed, VALUE_WIDTH)
// rsp       out        rsp_valid / rsp_stall     rsp_character (8), rsp_last (1)
//
// One number is converted at a time: the sequencer takes it, runs VALUE_WIDTH
// shift-add-3 steps in the BCD register, sends the sign of a negative value,
// then skips leading zeros and sends the digits.
// Reset is synchronous and clears the sequencer and the output valid.
// A stalled result holds in the output register; the sequencer waits for it,
// and takes the next number once the last character is in that register.
`timescale 1ns / 1ps

module signed_int_to_decimal_ascii_unit #(
   parameter int VALUE_WIDTH = sitda_pkg::VALUE_WIDTH_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [VALUE_WIDTH-1:0] req_value,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [7:0]                    rsp_character,
   output logic                          rsp_last
);

   sitda_pkg::cmd_type    cmd;
   sitda_pkg::status_type status;

   sitda_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   sitda_dp #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .req_value     (req_value),
      .cmd           (cmd),
      .status        (status),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_character (rsp_character),
      .rsp_last      (rsp_last)
   );

endmodule

[rtl/sitda_ctrl.sv]
`timescale 1ns / 1ps

module sitda_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  sitda_pkg::status_type status,
   output sitda_pkg::cmd_type    cmd
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_CONV  = 3'd1;
   localparam logic [2:0] ST_SIGN  = 3'd2;
   localparam logic [2:0] ST_STRIP = 3'd3;
   localparam logic [2:0] ST_EMIT  = 3'd4;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_CONV;
            end
         end
         ST_CONV: begin
            cmd.conv_step = 1'b1;
            if (status.conv_last) begin
               state_in = status.negative ? ST_SIGN : ST_STRIP;
            end
         end
         ST_SIGN: begin
            if (status.out_free) begin
               cmd.emit_sign = 1'b1;
               state_in      = ST_STRIP;
            end
         end
         ST_STRIP: begin
            // Leading zeros are dropped, but the units digit always stays.
            if (status.top_zero && !status.one_left) begin
               cmd.drop_digit = 1'b1;
            end else begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (status.out_free) begin
               cmd.emit_digit = 1'b1;
               if (status.one_left) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

[rtl/sitda_dp.sv]
`timescale 1ns / 1ps

module sitda_dp #(
   parameter int VALUE_WIDTH = sitda_pkg::VALUE_WIDTH_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic signed [VALUE_WIDTH-1:0] req_value,
   input  sitda_pkg::cmd_type           cmd,
   output sitda_pkg::status_type        status,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [7:0]                   rsp_character,
   output logic                         rsp_last
);

   localparam int NUM_DIGITS = sitda_pkg::num_digits(VALUE_WIDTH);
   localparam int BCD_W      = NUM_DIGITS * 4;
   localparam int BIT_CNT_W  = $clog2(VALUE_WIDTH + 1);
   localparam int DIG_CNT_W  = $clog2(NUM_DIGITS + 1);

   logic [VALUE_WIDTH-1:0] mag_ff, mag_in;
   logic [BCD_W-1:0]       bcd_ff, bcd_in;
   logic                   neg_ff, neg_in;
   logic [BIT_CNT_W-1:0]   bit_cnt_ff, bit_cnt_in;
   logic [DIG_CNT_W-1:0]   dig_left_ff, dig_left_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [7:0]             rsp_character_ff, rsp_character_in;
   logic                   rsp_last_ff, rsp_last_in;

   logic [BCD_W-1:0]       bcd_adj;
   logic [VALUE_WIDTH-1:0] value_bits;
   logic [3:0]             top_digit;

   assign value_bits = req_value;
   assign top_digit  = bcd_ff[BCD_W-1 -: 4];

   // Add-3 correction on every digit before the shift.
   always_comb begin
      for (int i = 0; i < NUM_DIGITS; i++) begin
         if (bcd_ff[i*4 +: 4] >= 4'd5) begin
            bcd_adj[i*4 +: 4] = bcd_ff[i*4 +: 4] + 4'd3;
         end else begin
            bcd_adj[i*4 +: 4] = bcd_ff[i*4 +: 4];
         end
      end
   end

   assign status.conv_last = (bit_cnt_ff == BIT_CNT_W'(1));
   assign status.negative  = neg_ff;
   assign status.top_zero  = (top_digit == 4'd0);
   assign status.one_left  = (dig_left_ff == DIG_CNT_W'(1));
   assign status.out_free  = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      mag_in           = mag_ff;
      bcd_in           = bcd_ff;
      neg_in           = neg_ff;
      bit_cnt_in       = bit_cnt_ff;
      dig_left_in      = dig_left_ff;
      rsp_valid_in     = rsp_valid_ff;
      rsp_character_in = rsp_character_ff;
      rsp_last_in      = rsp_last_ff;

      if (cmd.load) begin
         neg_in      = value_bits[VALUE_WIDTH-1];
         // The most negative value negates to 2^(W-1), exact as unsigned.
         mag_in      = value_bits[VALUE_WIDTH-1] ? (~value_bits + 1'b1) : value_bits;
         bcd_in      = '0;
         bit_cnt_in  = BIT_CNT_W'(VALUE_WIDTH);
         dig_left_in = DIG_CNT_W'(NUM_DIGITS);
      end

      if (cmd.conv_step) begin
         bcd_in     = {bcd_adj[BCD_W-2:0], mag_ff[VALUE_WIDTH-1]};
         mag_in     = {mag_ff[VALUE_WIDTH-2:0], 1'b0};
         bit_cnt_in = bit_cnt_ff - 1'b1;
      end

      if (cmd.drop_digit || cmd.emit_digit) begin
         bcd_in      = {bcd_ff[BCD_W-5:0], 4'd0};
         dig_left_in = dig_left_ff - 1'b1;
      end

      if (cmd.emit_sign) begin
         rsp_valid_in     = 1'b1;
         rsp_character_in = sitda_pkg::CHAR_MINUS;
         rsp_last_in      = 1'b0;
      end else if (cmd.emit_digit) begin
         rsp_valid_in     = 1'b1;
         rsp_character_in = sitda_pkg::CHAR_ZERO + {4'd0, top_digit};
         rsp_last_in      = status.one_left;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         bit_cnt_ff   <= '0;
         dig_left_ff  <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         bit_cnt_ff   <= bit_cnt_in;
         dig_left_ff  <= dig_left_in;
      end
      mag_ff           <= mag_in;
      bcd_ff           <= bcd_in;
      neg_ff           <= neg_in;
      rsp_character_ff <= rsp_character_in;
      rsp_last_ff      <= rsp_last_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_character = rsp_character_ff;
   assign rsp_last      = rsp_last_ff;

endmodule

[rtl/sitda_checker.sv]
`timescale 1ns / 1ps

module sitda_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [7:0] rsp_character,
   input logic       rsp_last
);

   // A stalled character stays put until its transfer.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_character) && $stable(rsp_last))
      else $error("stalled result changed");

   a_char_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_character == sitda_pkg::CHAR_MINUS) ||
                    (rsp_character >= sitda_pkg::CHAR_ZERO &&
                     rsp_character <= sitda_pkg::CHAR_ZERO + 8'd9))
      else $error("result is neither a digit nor a minus sign");

   a_sign_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_character == sitda_pkg::CHAR_MINUS |-> !rsp_last)
      else $error("minus sign flagged as last character");

   // The converter is busy right after it takes a number.
   a_busy_after_take: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second number taken back to back");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind signed_int_to_decimal_ascii_unit sitda_checker u_sitda_checker (.*);
